// ----- design/sorted_priority_queue_assert.svh -----
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTH
`define SPQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SPQ_ASSERT_SAME(lbl, ante, cons, msg)
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- design/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Beat types, request and status codes, and the per-cell command.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int SPQ_DEPTH = 16;

  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic               req_type;
    logic signed [15:0] data_in;
    logic        [7:0]  prio_in;
  } in_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [15:0] data_out;
    logic        [7:0]  prio_out;
  } out_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic        [7:0]  prio;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   ent;
  } cell_cmd_t;

endpackage

// ----- design/spq_cell.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot: keeps, takes the new entry, or shifts from a neighbor.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_cmd_t cmd,
  input  logic               live,
  input  logic               left_ge,
  input  spq_pkg::entry_t    left_ent,
  input  spq_pkg::entry_t    right_ent,
  output spq_pkg::entry_t    ent,
  output logic               ge
);

  spq_pkg::entry_t ent_r;
  spq_pkg::entry_t ent_nxt;

  assign ent = ent_r;
  assign ge  = live && (ent_r.prio >= cmd.ent.prio);

  always_comb begin
    ent_nxt = ent_r;
    unique case (cmd.op)
      spq_pkg::OP_INSERT: begin
        if (!ge) begin
          ent_nxt = left_ge ? cmd.ent : left_ent;
        end
      end
      spq_pkg::OP_REMOVE: begin
        ent_nxt = right_ent;
      end
      default: begin
        ent_nxt = ent_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

// ----- design/sorted_priority_queue.sv -----
// Latency: a request taken at one edge has its result strobed on out_valid in the next cycle.
// Throughput: one request per cycle; busy stays low, the cell row inserts or shifts in one step.
// The receiver cannot stall: every result is shown for exactly one cycle.
// Reset (rst_n low, synchronous) empties the queue and drops any pending strobe.
// ----------------------------------------------------------------------------
// Sorted priority queue
// Row of compare-and-shift cells kept sorted by priority, highest at cell 0.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_assert.svh"

module sorted_priority_queue #(
  parameter int QUEUE_DEPTH = spq_pkg::SPQ_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  spq_pkg::in_t  in_data,
  output logic          out_valid,
  output spq_pkg::out_t out_data
);

  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

  logic [OCC_W-1:0]   occ_r;
  logic [OCC_W-1:0]   occ_nxt;
  logic               out_valid_r;
  spq_pkg::out_t      out_r;
  spq_pkg::out_t      out_nxt;
  spq_pkg::cell_cmd_t cmd;
  logic               full;
  logic               empty;
  logic               enq_take;

  spq_pkg::entry_t    ent [QUEUE_DEPTH];
  logic               ge  [QUEUE_DEPTH];
  logic               live [QUEUE_DEPTH];

  assign busy      = 1'b0;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign full  = (occ_r == OCC_W'(QUEUE_DEPTH));
  assign empty = (occ_r == '0);

  assign enq_take = start && (in_data.req_type == spq_pkg::REQ_ENQ) && !full;

  always_comb begin
    cmd.op        = spq_pkg::OP_HOLD;
    cmd.ent.value = in_data.data_in;
    cmd.ent.prio  = in_data.prio_in;
    occ_nxt       = occ_r;
    out_nxt       = '0;
    if (start) begin
      if (in_data.req_type == spq_pkg::REQ_ENQ) begin
        if (full) begin
          out_nxt.status = spq_pkg::ST_FULL;
        end else begin
          cmd.op  = spq_pkg::OP_INSERT;
          occ_nxt = occ_r + 1'b1;
        end
      end else begin
        if (empty) begin
          out_nxt.status = spq_pkg::ST_EMPTY;
        end else begin
          cmd.op           = spq_pkg::OP_REMOVE;
          occ_nxt          = occ_r - 1'b1;
          out_nxt.data_out = ent[0].value;
          out_nxt.prio_out = ent[0].prio;
        end
      end
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    spq_pkg::entry_t left_ent;
    spq_pkg::entry_t right_ent;
    logic            left_ge;

    assign live[i] = (OCC_W'(i) < occ_r);

    if (i == 0) begin : g_head
      assign left_ge  = 1'b1;
      assign left_ent = cmd.ent;
    end else begin : g_body
      assign left_ge  = ge[i-1];
      assign left_ent = ent[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_ent = ent[i];
    end else begin : g_inner
      assign right_ent = ent[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .live      (live[i]),
      .left_ge   (left_ge),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .ent       (ent[i]),
      .ge        (ge[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      out_valid_r <= start;
    end
    out_r <= out_nxt;
  end

  `SPQ_ASSERT_SAME(a_occ_bound, 1'b1, occ_r <= OCC_W'(QUEUE_DEPTH), "occupancy over depth")
  `SPQ_ASSERT_NEXT(a_strobe, start, out_valid, "request without result strobe")
  `SPQ_ASSERT_NEXT(a_no_strobe, !start, !out_valid, "result strobe without request")
  `SPQ_ASSERT_NEXT(a_enq_count, enq_take, occ_r == $past(occ_r) + 1'b1, "enqueue not counted")
  `SPQ_ASSERT_SAME(a_head_sorted, occ_r >= OCC_W'(2), ent[0].prio >= ent[1].prio, "head order")

endmodule
